@@ src/vfcm_pkg.sv @@
package vfcm_pkg;

  // Chunk geometry. The edge is a power of two, so a cell index is the
  // concatenation {x, y, z} of three coordinate fields.
  localparam int CHUNK_EDGE = 32;
  localparam int COORD_W    = $clog2(CHUNK_EDGE);
  localparam int CELL_W     = 3 * COORD_W;
  localparam int CELLS      = CHUNK_EDGE * CHUNK_EDGE * CHUNK_EDGE;

  localparam int TYPE_W     = 8;
  localparam int CORNER_W   = 6;
  localparam int TEX_W      = 5;
  localparam int FACE_W     = 3;
  localparam int VTX_W      = 3;
  localparam int FACE_COUNT = 6;
  localparam int VTX_COUNT  = 6;

  localparam logic [COORD_W-1:0] COORD_TOP = COORD_W'(CHUNK_EDGE - 1);
  localparam logic [CELL_W-1:0]  CELL_LAST = CELL_W'(CELLS - 1);
  localparam logic [VTX_W-1:0]   VTX_LAST  = VTX_W'(VTX_COUNT - 1);

  // Register indexes. The index is the word address on the register port.
  localparam logic REG_AIR_CODE = 1'b0;

  // Item modes.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EMIT  = 1'b1;

  // Face codes, in emission order.
  localparam logic [FACE_W-1:0] FACE_NZ = 3'd0;
  localparam logic [FACE_W-1:0] FACE_PZ = 3'd1;
  localparam logic [FACE_W-1:0] FACE_NX = 3'd2;
  localparam logic [FACE_W-1:0] FACE_PX = 3'd3;
  localparam logic [FACE_W-1:0] FACE_NY = 3'd4;
  localparam logic [FACE_W-1:0] FACE_PY = 3'd5;
  localparam logic [FACE_W-1:0] FACE_END = FACE_W'(FACE_COUNT);

  // Corner offsets {x, y, z} per face and vertex.
  localparam logic [2:0] CORNER_TAB [FACE_COUNT][VTX_COUNT] = '{
    '{3'b000, 3'b100, 3'b110, 3'b110, 3'b010, 3'b000},
    '{3'b001, 3'b101, 3'b111, 3'b111, 3'b011, 3'b001},
    '{3'b011, 3'b010, 3'b000, 3'b000, 3'b001, 3'b011},
    '{3'b111, 3'b110, 3'b100, 3'b100, 3'b101, 3'b111},
    '{3'b000, 3'b100, 3'b101, 3'b101, 3'b001, 3'b000},
    '{3'b010, 3'b110, 3'b111, 3'b111, 3'b011, 3'b010}
  };

  // Texture corner offsets {u, v} per vertex.
  localparam logic [1:0] UV_TAB [VTX_COUNT] = '{
    2'b01, 2'b11, 2'b10, 2'b10, 2'b00, 2'b01
  };

  typedef struct packed {
    logic                mode;
    logic [CELL_W-1:0]   cell_index;
    logic [TYPE_W-1:0]   wr_type;
  } in_item_t;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
    logic [CORNER_W-1:0] corner_z;
    logic [TYPE_W-1:0]   vertex_type;
    logic [FACE_W-1:0]   face;
    logic [TEX_W-1:0]    tex_u;
    logic [TEX_W-1:0]    tex_v;
    logic                last;
  } out_item_t;

  // Access to the block store: one write and one read address per cycle.
  typedef struct packed {
    logic                we;
    logic [CELL_W-1:0]   waddr;
    logic [TYPE_W-1:0]   wdata;
    logic [CELL_W-1:0]   raddr;
  } store_req_t;

  // One vertex to be built and loaded into the output register.
  typedef struct packed {
    logic                fire;
    logic [COORD_W-1:0]  x;
    logic [COORD_W-1:0]  y;
    logic [COORD_W-1:0]  z;
    logic [TYPE_W-1:0]   vtype;
    logic [FACE_W-1:0]   face;
    logic [VTX_W-1:0]    vtx;
    logic                last;
  } vtx_req_t;

endpackage

@@ src/vfcm_store.sv @@
module vfcm_store (
  input  logic                             clk,
  input  vfcm_pkg::store_req_t             req,
  output logic [vfcm_pkg::TYPE_W-1:0]      rd_data
);

  logic [vfcm_pkg::TYPE_W-1:0] mem [vfcm_pkg::CELLS];
  logic [vfcm_pkg::TYPE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ src/vfcm_vgen.sv @@
module vfcm_vgen (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vfcm_pkg::vtx_req_t   req,
  output logic                 slot_free,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vfcm_pkg::out_item_t  out_data
);

  logic                out_valid_r;
  vfcm_pkg::out_item_t out_data_r;
  vfcm_pkg::out_item_t vtx_nxt;
  logic [2:0]          corner;
  logic [1:0]          uv;

  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    corner               = vfcm_pkg::CORNER_TAB[req.face][req.vtx];
    uv                   = vfcm_pkg::UV_TAB[req.vtx];
    vtx_nxt.corner_x     = vfcm_pkg::CORNER_W'(req.x) + vfcm_pkg::CORNER_W'(corner[2]);
    vtx_nxt.corner_y     = vfcm_pkg::CORNER_W'(req.y) + vfcm_pkg::CORNER_W'(corner[1]);
    vtx_nxt.corner_z     = vfcm_pkg::CORNER_W'(req.z) + vfcm_pkg::CORNER_W'(corner[0]);
    vtx_nxt.vertex_type  = req.vtype;
    vtx_nxt.face         = req.face;
    vtx_nxt.tex_u        = vfcm_pkg::TEX_W'(req.vtype[3:0]) + vfcm_pkg::TEX_W'(uv[1]);
    vtx_nxt.tex_v        = vfcm_pkg::TEX_W'(req.vtype[7:4]) + vfcm_pkg::TEX_W'(uv[0]);
    vtx_nxt.last         = req.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= req.fire;
    end
  end

  always_ff @(posedge clk) begin
    if (slot_free && req.fire) begin
      out_data_r <= vtx_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ src/vfcm_ctrl.sv @@
module vfcm_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  vfcm_pkg::in_item_t               in_data,
  output logic                             idle,
  input  logic [vfcm_pkg::TYPE_W-1:0]      air_code,
  output vfcm_pkg::store_req_t             store_req,
  input  logic [vfcm_pkg::TYPE_W-1:0]      rd_data,
  input  logic                             slot_free,
  output vfcm_pkg::vtx_req_t               vtx_req
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CENTER,
    ST_NBR,
    ST_START,
    ST_EMIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [vfcm_pkg::CELL_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [vfcm_pkg::COORD_W-1:0]    x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [vfcm_pkg::TYPE_W-1:0]     type_r, type_nxt;
  logic [vfcm_pkg::FACE_W-1:0]     f_r, f_nxt;
  logic                            chk_r, chk_nxt;
  logic [vfcm_pkg::FACE_W-1:0]     chk_face_r, chk_face_nxt;
  logic [vfcm_pkg::FACE_COUNT-1:0] mask_r, mask_nxt;
  logic [vfcm_pkg::FACE_W-1:0]     face_r, face_nxt;
  logic [vfcm_pkg::VTX_W-1:0]      vtx_r, vtx_nxt;

  logic                            nbr_in;
  logic [vfcm_pkg::COORD_W-1:0]    nx, ny, nz;
  logic                            first_found, more_found;
  logic [vfcm_pkg::FACE_W-1:0]     first_face, more_face;

  // Neighbor across face f_r and whether it lies inside the chunk.
  always_comb begin
    nx     = x_r;
    ny     = y_r;
    nz     = z_r;
    nbr_in = 1'b0;
    unique case (f_r)
      vfcm_pkg::FACE_NZ: begin
        nbr_in = (z_r != '0);
        nz     = z_r - 1'b1;
      end
      vfcm_pkg::FACE_PZ: begin
        nbr_in = (z_r != vfcm_pkg::COORD_TOP);
        nz     = z_r + 1'b1;
      end
      vfcm_pkg::FACE_NX: begin
        nbr_in = (x_r != '0);
        nx     = x_r - 1'b1;
      end
      vfcm_pkg::FACE_PX: begin
        nbr_in = (x_r != vfcm_pkg::COORD_TOP);
        nx     = x_r + 1'b1;
      end
      vfcm_pkg::FACE_NY: begin
        nbr_in = (y_r != '0);
        ny     = y_r - 1'b1;
      end
      vfcm_pkg::FACE_PY: begin
        nbr_in = (y_r != vfcm_pkg::COORD_TOP);
        ny     = y_r + 1'b1;
      end
      default: begin
        nbr_in = 1'b0;
      end
    endcase
  end

  // Lowest open face overall, and lowest open face above the current one.
  always_comb begin
    first_found = 1'b0;
    first_face  = '0;
    more_found  = 1'b0;
    more_face   = '0;
    for (int i = vfcm_pkg::FACE_COUNT - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        first_found = 1'b1;
        first_face  = vfcm_pkg::FACE_W'(i);
        if (vfcm_pkg::FACE_W'(i) > face_r) begin
          more_found = 1'b1;
          more_face  = vfcm_pkg::FACE_W'(i);
        end
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    z_nxt        = z_r;
    type_nxt     = type_r;
    f_nxt        = f_r;
    chk_nxt      = chk_r;
    chk_face_nxt = chk_face_r;
    mask_nxt     = mask_r;
    face_nxt     = face_r;
    vtx_nxt      = vtx_r;

    idle            = 1'b0;
    store_req.we    = 1'b0;
    store_req.waddr = in_data.cell_index;
    store_req.wdata = in_data.wr_type;
    store_req.raddr = in_data.cell_index;

    vtx_req.fire  = 1'b0;
    vtx_req.x     = x_r;
    vtx_req.y     = y_r;
    vtx_req.z     = z_r;
    vtx_req.vtype = type_r;
    vtx_req.face  = face_r;
    vtx_req.vtx   = vtx_r;
    vtx_req.last  = (vtx_r == vfcm_pkg::VTX_LAST) && !more_found;

    unique case (state_r)
      ST_CLEAR: begin
        store_req.we    = 1'b1;
        store_req.waddr = clr_cnt_r;
        store_req.wdata = '0;
        clr_cnt_nxt     = clr_cnt_r + 1'b1;
        if (clr_cnt_r == vfcm_pkg::CELL_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          if (in_data.mode == vfcm_pkg::MODE_WRITE) begin
            store_req.we = 1'b1;
          end else begin
            // The center cell read is issued with the transfer itself.
            x_nxt     = in_data.cell_index[vfcm_pkg::CELL_W-1 -: vfcm_pkg::COORD_W];
            y_nxt     = in_data.cell_index[vfcm_pkg::COORD_W +: vfcm_pkg::COORD_W];
            z_nxt     = in_data.cell_index[0 +: vfcm_pkg::COORD_W];
            state_nxt = ST_CENTER;
          end
        end
      end
      ST_CENTER: begin
        type_nxt = rd_data;
        mask_nxt = '0;
        f_nxt    = '0;
        chk_nxt  = 1'b0;
        state_nxt = (rd_data == air_code) ? ST_IDLE : ST_NBR;
      end
      ST_NBR: begin
        // Result of the previous neighbor read lands this cycle.
        if (chk_r) begin
          mask_nxt[chk_face_r] = (rd_data == air_code);
        end
        if (f_r != vfcm_pkg::FACE_END) begin
          store_req.raddr = {nx, ny, nz};
          chk_nxt         = nbr_in;
          chk_face_nxt    = f_r;
          if (!nbr_in) begin
            mask_nxt[f_r] = 1'b1;
          end
          f_nxt = f_r + 1'b1;
        end else begin
          chk_nxt   = 1'b0;
          state_nxt = ST_START;
        end
      end
      ST_START: begin
        face_nxt  = first_face;
        vtx_nxt   = '0;
        state_nxt = first_found ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        vtx_req.fire = slot_free;
        if (slot_free) begin
          if (vtx_r == vfcm_pkg::VTX_LAST) begin
            vtx_nxt = '0;
            if (more_found) begin
              face_nxt = more_face;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            vtx_nxt = vtx_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_cnt_r  <= '0;
      f_r        <= '0;
      chk_r      <= 1'b0;
      chk_face_r <= '0;
      mask_r     <= '0;
      face_r     <= '0;
      vtx_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      f_r        <= f_nxt;
      chk_r      <= chk_nxt;
      chk_face_r <= chk_face_nxt;
      mask_r     <= mask_nxt;
      face_r     <= face_nxt;
      vtx_r      <= vtx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    type_r <= type_nxt;
  end

endmodule

@@ src/voxel_face_culling_mesher_core.sv @@
// Face-culling mesher for one 32x32x32 chunk of 8-bit block types.
// Input channel (in_valid, in_stall, in_data): each transfer either writes a
// block type into a cell or asks for the mesh vertices of a cell. The cell
// index is {x, y, z}, five bits each.
// Result channel (out_valid, out_stall, out_data): one transfer per vertex,
// six per visible face, faces in the order -z, +z, -x, +x, -y, +y. The final
// vertex of a cell carries last. Air cells and writes give no transfers.
// Configuration: an APB-style port holds air_code at byte address 0.
// Timing: a write leaves the block idle and ready for the next item. An emit reads
// the center cell and then the six neighbors through the single read port of the
// block store, one read per cycle, then picks the lowest open face and loads the
// vertices into the output register; an air cell goes back to idle after the
// center read.
// Reset: after rst_n the block sweeps the store to zero, one cell a cycle,
// for 32768 cycles; in_stall stays high during the sweep, while configuration
// writes are taken as usual.
// When the receiver stalls, the vertex in the output register holds and the
// vertex sequencer waits; input is only taken again once the last vertex of
// the cell has been loaded into the output register.
module voxel_face_culling_mesher_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  vfcm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output vfcm_pkg::out_item_t  out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  logic [vfcm_pkg::TYPE_W-1:0] air_code_r;
  logic                        idle;
  logic                        slot_free;
  logic [vfcm_pkg::TYPE_W-1:0] rd_data;
  vfcm_pkg::store_req_t        store_req;
  vfcm_pkg::vtx_req_t          vtx_req;

  assign cfg_pready = 1'b1;

  // The user must write the air code only while the block is idle; the block
  // does not enforce it. Register index: the word address bit of cfg_paddr.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      air_code_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 (cfg_paddr[2] == vfcm_pkg::REG_AIR_CODE)) begin
      air_code_r <= cfg_pwdata[vfcm_pkg::TYPE_W-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == vfcm_pkg::REG_AIR_CODE) begin
      cfg_prdata = 32'(air_code_r);
    end
  end

  assign in_stall = !idle;

  vfcm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .idle      (idle),
    .air_code  (air_code_r),
    .store_req (store_req),
    .rd_data   (rd_data),
    .slot_free (slot_free),
    .vtx_req   (vtx_req)
  );

  vfcm_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (rd_data)
  );

  vfcm_vgen u_vgen (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (vtx_req),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
